// ===== rtl/idll_pkg.sv =====
`default_nettype none

package idll_pkg;

    localparam int NODE_SLOTS  = 1024;
    localparam int ID_W        = 10;
    localparam int ADDR_W      = $clog2(NODE_SLOTS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_UNLINK     = 2'd0,
        CMD_INS_BEFORE = 2'd1,
        CMD_INS_AFTER  = 2'd2,
        CMD_QUERY      = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_WR_1,
        ST_WR_2
    } t_state;

    typedef struct packed {
        t_cmd            cmd;
        logic [ID_W-1:0] node;
        logic [ID_W-1:0] other;
        logic            node_ok;
        logic            other_ok;
        logic            same;
    } t_item;

    function automatic logic id_ok(input logic [ID_W-1:0] id);
        return (id != '0) && (32'(id) < NODE_SLOTS);
    endfunction

    function automatic logic [ADDR_W-1:0] to_addr(input logic [ID_W-1:0] id);
        return ADDR_W'(32'(id));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/idll_front.sv =====
`default_nettype none

module idll_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_busy,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic [1:0]     i_cmd,
    input  wire logic [9:0]     i_node_id,
    input  wire logic [9:0]     i_other_id,
    output logic                o_push_valid,
    input  wire logic           i_push_ready,
    output idll_pkg::t_item     o_push_item
);
    import idll_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    always_comb begin
        n_item.cmd      = t_cmd'(i_cmd);
        n_item.node     = i_node_id;
        n_item.other    = i_other_id;
        n_item.node_ok  = id_ok(i_node_id);
        n_item.other_ok = id_ok(i_other_id);
        n_item.same     = (i_node_id == i_other_id);
    end

    assign o_in_ready   = !i_busy && (!r_valid || i_push_ready);
    assign o_push_valid = r_valid;
    assign o_push_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/idll_queue.sv =====
`default_nettype none

module idll_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push_valid,
    output logic                 o_push_ready,
    input  wire idll_pkg::t_item i_push_item,
    output logic                 o_pop_valid,
    input  wire logic            i_pop_ready,
    output idll_pkg::t_item      o_pop_item
);
    import idll_pkg::*;

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == QUEUE_DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == QUEUE_DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/idll_back.sv =====
`default_nettype none

module idll_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    output logic                 o_busy,
    input  wire logic            i_q_valid,
    output logic                 o_q_ready,
    input  wire idll_pkg::t_item i_q_item,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output logic                 o_status,
    output logic [9:0]           o_prev_id,
    output logic [9:0]           o_next_id
);
    import idll_pkg::*;

    logic [ID_W-1:0]   r_prev_mem [NODE_SLOTS];
    logic [ID_W-1:0]   r_next_mem [NODE_SLOTS];
    logic [ID_W-1:0]   r_prev_q;
    logic [ID_W-1:0]   r_next_q;

    t_state            r_state, n_state;
    t_item             r_item, n_item;
    logic [ID_W-1:0]   r_sp, n_sp;
    logic [ID_W-1:0]   r_sn, n_sn;
    logic [ID_W-1:0]   r_link, n_link;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic              r_out_valid, n_out_valid;
    logic              r_status, n_status;
    logic [ID_W-1:0]   r_prev, n_prev;
    logic [ID_W-1:0]   r_next, n_next;

    logic              prev_we, next_we;
    logic [ADDR_W-1:0] prev_waddr, next_waddr;
    logic [ID_W-1:0]   prev_wdata, next_wdata;
    logic [ADDR_W-1:0] prev_raddr, next_raddr;
    logic              out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_busy      = (r_state == ST_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_prev_id   = r_prev;
    assign o_next_id   = r_next;

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_sp        = r_sp;
        n_sn        = r_sn;
        n_link      = r_link;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_prev      = r_prev;
        n_next      = r_next;
        o_q_ready   = 1'b0;
        prev_we     = 1'b0;
        next_we     = 1'b0;
        prev_waddr  = '0;
        next_waddr  = '0;
        prev_wdata  = '0;
        next_wdata  = '0;
        prev_raddr  = to_addr(r_item.node);
        next_raddr  = to_addr(r_item.node);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                prev_we    = 1'b1;
                next_we    = 1'b1;
                prev_waddr = r_clr_addr;
                next_waddr = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (32'(r_clr_addr) == NODE_SLOTS - 1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_ready = 1'b1;
                    n_item    = i_q_item;
                    if (i_q_item.cmd == CMD_UNLINK || i_q_item.cmd == CMD_QUERY) begin
                        prev_raddr = to_addr(i_q_item.node);
                        next_raddr = to_addr(i_q_item.node);
                    end else begin
                        prev_raddr = to_addr(i_q_item.other);
                        next_raddr = to_addr(i_q_item.other);
                    end
                    n_state = ST_RD_A;
                end
            end
            ST_RD_A: begin
                n_sp = r_prev_q;
                n_sn = r_next_q;
                unique case (r_item.cmd)
                    CMD_QUERY: begin
                        n_out_valid = 1'b1;
                        n_status    = 1'b0;
                        n_prev      = r_item.node_ok ? r_prev_q : '0;
                        n_next      = r_item.node_ok ? r_next_q : '0;
                        n_state     = ST_IDLE;
                    end
                    CMD_UNLINK: begin
                        n_state = r_item.node_ok ? ST_WR_1 : ST_IDLE;
                    end
                    CMD_INS_BEFORE, CMD_INS_AFTER: begin
                        n_state = ST_RD_B;
                    end
                endcase
            end
            ST_RD_B: begin
                if (!r_item.node_ok || !r_item.other_ok || r_item.same ||
                    r_sp != '0 || r_sn != '0) begin
                    n_out_valid = 1'b1;
                    n_status    = 1'b1;
                    n_prev      = '0;
                    n_next      = '0;
                    n_state     = ST_IDLE;
                end else begin
                    n_link  = (r_item.cmd == CMD_INS_AFTER) ? r_next_q : r_prev_q;
                    n_state = ST_WR_1;
                end
            end
            ST_WR_1: begin
                unique case (r_item.cmd)
                    CMD_UNLINK: begin
                        next_we    = id_ok(r_sp);
                        next_waddr = to_addr(r_sp);
                        next_wdata = r_sn;
                        prev_we    = id_ok(r_sn);
                        prev_waddr = to_addr(r_sn);
                        prev_wdata = r_sp;
                    end
                    CMD_INS_AFTER: begin
                        prev_we    = id_ok(r_link);
                        prev_waddr = to_addr(r_link);
                        prev_wdata = r_item.other;
                        next_we    = id_ok(r_link);
                        next_waddr = to_addr(r_item.other);
                        next_wdata = r_link;
                    end
                    CMD_INS_BEFORE: begin
                        next_we    = id_ok(r_link);
                        next_waddr = to_addr(r_link);
                        next_wdata = r_item.other;
                        prev_we    = id_ok(r_link);
                        prev_waddr = to_addr(r_item.other);
                        prev_wdata = r_link;
                    end
                    CMD_QUERY: begin
                    end
                endcase
                n_state = ST_WR_2;
            end
            ST_WR_2: begin
                unique case (r_item.cmd)
                    CMD_UNLINK: begin
                        prev_we    = 1'b1;
                        prev_waddr = to_addr(r_item.node);
                        next_we    = 1'b1;
                        next_waddr = to_addr(r_item.node);
                    end
                    CMD_INS_AFTER: begin
                        next_we    = 1'b1;
                        next_waddr = to_addr(r_item.node);
                        next_wdata = r_item.other;
                        prev_we    = 1'b1;
                        prev_waddr = to_addr(r_item.other);
                        prev_wdata = r_item.node;
                    end
                    CMD_INS_BEFORE: begin
                        next_we    = 1'b1;
                        next_waddr = to_addr(r_item.other);
                        next_wdata = r_item.node;
                        prev_we    = 1'b1;
                        prev_waddr = to_addr(r_item.node);
                        prev_wdata = r_item.other;
                    end
                    CMD_QUERY: begin
                    end
                endcase
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_sp     <= n_sp;
        r_sn     <= n_sn;
        r_link   <= n_link;
        r_status <= n_status;
        r_prev   <= n_prev;
        r_next   <= n_next;
    end

    // link memories, one write and one registered read port each
    always_ff @(posedge i_clk) begin
        if (prev_we) begin
            r_prev_mem[prev_waddr] <= prev_wdata;
        end
        r_prev_q <= r_prev_mem[prev_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            r_next_mem[next_waddr] <= next_wdata;
        end
        r_next_q <= r_next_mem[next_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/indexed_doubly_linked_list.sv =====
`default_nettype none

// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_cmd, i_node_id, i_other_id
// out       output     o_out_valid / i_out_ready  o_status, o_prev_id, o_next_id
//
// the back end runs one item at a time on two link memories with one write and one
// registered read port each: query reads and answers; unlink reads, relinks, zeroes the
// node (a bad id stops after the read); insert reads both ids, then rejects or relinks
// after reset a clearing pass zeroes all 1024 entries, o_in_ready low meanwhile
// a register stage and a 2-entry queue sit in front, so items are taken while the
// back end works or while a result waits on i_out_ready

module indexed_doubly_linked_list (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_cmd,
    input  wire logic [9:0] i_node_id,
    input  wire logic [9:0] i_other_id,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_status,
    output logic [9:0]      o_prev_id,
    output logic [9:0]      o_next_id
);
    import idll_pkg::*;

    logic  busy;
    logic  push_valid;
    logic  push_ready;
    t_item push_item;
    logic  q_valid;
    logic  q_ready;
    t_item q_item;

    idll_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_busy       (busy),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_node_id    (i_node_id),
        .i_other_id   (i_other_id),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_item  (push_item)
    );

    idll_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_item   (q_item)
    );

    idll_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .o_busy       (busy),
        .i_q_valid    (q_valid),
        .o_q_ready    (q_ready),
        .i_q_item     (q_item),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_prev_id    (o_prev_id),
        .o_next_id    (o_next_id)
    );

endmodule

`default_nettype wire
